[hw/rtl/sme_pkg.sv]
// shared types and constants for the stack machine executor
// no dependencies
`default_nettype none

package sme_pkg;

    localparam int DATA_W              = 32;
    localparam int DEF_STACK_DEPTH     = 256;
    localparam int DEF_MEM_WORDS       = 256;
    localparam int DEF_RETURN_DEPTH    = 64;
    localparam int DEF_PC_BITS         = 16;
    localparam int DIV_STEPS           = DATA_W;
    localparam int SHORT_STEP          = 1;
    localparam int LONG_STEP           = 5;

    // opcodes
    localparam logic [7:0] OP_HALT  = 8'd0;
    localparam logic [7:0] OP_PUSH  = 8'd1;
    localparam logic [7:0] OP_POP   = 8'd2;
    localparam logic [7:0] OP_ADD   = 8'd3;
    localparam logic [7:0] OP_SUB   = 8'd4;
    localparam logic [7:0] OP_MUL   = 8'd5;
    localparam logic [7:0] OP_DIV   = 8'd6;
    localparam logic [7:0] OP_CMP   = 8'd7;
    localparam logic [7:0] OP_STORE = 8'd8;
    localparam logic [7:0] OP_LOAD  = 8'd9;
    localparam logic [7:0] OP_JMP   = 8'd10;
    localparam logic [7:0] OP_JZ    = 8'd11;
    localparam logic [7:0] OP_JNZ   = 8'd12;
    localparam logic [7:0] OP_DUP   = 8'd13;
    localparam logic [7:0] OP_CALL  = 8'd14;
    localparam logic [7:0] OP_RET   = 8'd15;

    // fault codes
    localparam logic [2:0] FLT_NONE      = 3'd0;
    localparam logic [2:0] FLT_UNDERFLOW = 3'd1;
    localparam logic [2:0] FLT_OVERFLOW  = 3'd2;
    localparam logic [2:0] FLT_DIV_ZERO  = 3'd3;
    localparam logic [2:0] FLT_RET_UNDER = 3'd4;
    localparam logic [2:0] FLT_BAD_OP    = 3'd5;
    localparam logic [2:0] FLT_BAD_INDEX = 3'd6;
    localparam logic [2:0] FLT_RET_OVER  = 3'd7;

    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_SUB = 3'd1,
        ALU_MUL = 3'd2,
        ALU_DIV = 3'd3,
        ALU_CMP = 3'd4
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

endpackage

`default_nettype wire

[hw/rtl/stack_machine_executor.sv]
// stack machine executor: one bytecode instruction per input transaction, one status result
// depends on sme_pkg and sme_alu
// flow: accept, execute, then response; add/sub/mul/div/cmp without a fault also pass the alu
// state first; a new instruction is taken in idle, or in response once the output register is free
// reset: synchronous active low; afterwards a clearing pass zeroes
// the word memory while s_ready stays low
`default_nettype none

module stack_machine_executor import sme_pkg::*; #(
    parameter int STACK_DEPTH  = DEF_STACK_DEPTH,
    parameter int MEM_WORDS    = DEF_MEM_WORDS,
    parameter int RETURN_DEPTH = DEF_RETURN_DEPTH,
    parameter int PC_BITS      = DEF_PC_BITS
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_action,
    input  wire logic signed [31:0] s_immediate,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [15:0]             m_next_pc,
    output logic signed [31:0]      m_top_value,
    output logic [8:0]              m_depth,
    output logic                    m_halted,
    output logic [2:0]              m_fault,
    output logic [31:0]             m_executed_count
);

    localparam int LW  = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int RLW = $clog2(RETURN_DEPTH + 1);
    localparam int RAW = $clog2(RETURN_DEPTH);
    localparam int MAW = $clog2(MEM_WORDS);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_EXEC  = 5'b00100,
        ST_ALU   = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // architectural state; top of stack lives in a register, the rest in stack_mem
    logic [LW-1:0]      level_reg, level_next;
    logic [DATA_W-1:0]  top_reg, top_next;
    logic [RLW-1:0]     rlevel_reg, rlevel_next;
    logic [PC_BITS-1:0] pc_reg, pc_next;
    logic               stopped_reg, stopped_next;
    logic [2:0]         fault_reg, fault_next;
    logic [31:0]        tally_reg, tally_next;

    // latched instruction
    logic [7:0]         op_reg;
    logic [31:0]        imm_reg;
    logic [MAW-1:0]     clr_reg;

    // memories
    logic [DATA_W-1:0]  stack_mem [STACK_DEPTH];
    logic [PC_BITS-1:0] ret_mem [RETURN_DEPTH];
    logic [DATA_W-1:0]  word_mem [MEM_WORDS];
    logic [DATA_W-1:0]  stk_rd_reg;
    logic [PC_BITS-1:0] ret_rd_reg;
    logic [DATA_W-1:0]  wm_rd_reg;

    logic               stk_we;
    logic               ret_we;
    logic               wm_we;
    logic [MAW-1:0]     wm_wa;
    logic [DATA_W-1:0]  wm_wd;

    // output register
    logic               m_valid_reg;
    logic [15:0]        o_pc_reg;
    logic [31:0]        o_top_reg;
    logic [8:0]         o_depth_reg;
    logic               o_halted_reg;
    logic [2:0]         o_fault_reg;
    logic [31:0]        o_count_reg;

    alu_req_t           alu_req;
    logic               alu_done;
    logic [DATA_W-1:0]  alu_result;

    logic               out_free;
    logic               accept;
    logic               in_range;
    logic [PC_BITS-1:0] step1;
    logic [PC_BITS-1:0] step5;
    logic [PC_BITS-1:0] target;
    logic               stack_full;
    logic               stack_empty;

    assign out_free    = !m_valid_reg || m_ready;
    assign s_ready     = (state_reg == ST_IDLE) || ((state_reg == ST_RESP) && out_free);
    assign accept      = s_valid && s_ready;

    assign step1       = pc_reg + PC_BITS'(SHORT_STEP);
    assign step5       = pc_reg + PC_BITS'(LONG_STEP);
    assign target      = imm_reg[PC_BITS-1:0];
    // negative indexes look huge when compared unsigned
    assign in_range    = imm_reg < 32'(MEM_WORDS);
    assign stack_full  = level_reg == LW'(STACK_DEPTH);
    assign stack_empty = level_reg == '0;

    sme_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa     (stk_rd_reg),
        .opb     (top_reg),
        .done    (alu_done),
        .result  (alu_result)
    );

    // instruction decode and commit
    always_comb begin
        state_next   = state_reg;
        level_next   = level_reg;
        top_next     = top_reg;
        rlevel_next  = rlevel_reg;
        pc_next      = pc_reg;
        stopped_next = stopped_reg;
        fault_next   = fault_reg;
        tally_next   = tally_reg;
        stk_we       = 1'b0;
        ret_we       = 1'b0;
        wm_we        = 1'b0;
        wm_wa        = imm_reg[MAW-1:0];
        wm_wd        = top_reg;
        alu_req      = '{start: 1'b0, op: ALU_ADD};

        unique case (state_reg)
            ST_CLEAR: begin
                wm_we = 1'b1;
                wm_wa = clr_reg;
                wm_wd = '0;
                if (clr_reg == MAW'(MEM_WORDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_RESP;
                if (!stopped_reg) begin
                    if (tally_reg != '1) begin
                        tally_next = tally_reg + 1'b1;
                    end
                    unique case (op_reg) inside
                        OP_HALT: begin
                            stopped_next = 1'b1;
                        end
                        OP_PUSH: begin
                            if (stack_full) begin
                                stopped_next = 1'b1;
                                fault_next   = FLT_OVERFLOW;
                            end else begin
                                stk_we     = !stack_empty;
                                top_next   = imm_reg;
                                level_next = level_reg + 1'b1;
                                pc_next    = step5;
                            end
                        end
                        OP_POP: begin
                            if (stack_empty) begin
                                stopped_next = 1'b1;
                                fault_next   = FLT_UNDERFLOW;
                            end else begin
                                top_next   = stk_rd_reg;
                                level_next = level_reg - 1'b1;
                                pc_next    = step1;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP: begin
                            if (level_reg < LW'(2)) begin
                                stopped_next = 1'b1;
                                fault_next   = FLT_UNDERFLOW;
                            end else if (op_reg == OP_DIV && top_reg == '0) begin
                                // divisor is dropped before stopping
                                stopped_next = 1'b1;
                                fault_next   = FLT_DIV_ZERO;
                                top_next     = stk_rd_reg;
                                level_next   = level_reg - 1'b1;
                            end else begin
                                alu_req.start = 1'b1;
                                case (op_reg)
                                    OP_ADD:  alu_req.op = ALU_ADD;
                                    OP_SUB:  alu_req.op = ALU_SUB;
                                    OP_MUL:  alu_req.op = ALU_MUL;
                                    OP_DIV:  alu_req.op = ALU_DIV;
                                    default: alu_req.op = ALU_CMP;
                                endcase
                                state_next = ST_ALU;
                            end
                        end
                        OP_STORE: begin
                            if (stack_empty) begin
                                stopped_next = 1'b1;
                                fault_next   = FLT_UNDERFLOW;
                            end else if (!in_range) begin
                                stopped_next = 1'b1;
                                fault_next   = FLT_BAD_INDEX;
                            end else begin
                                wm_we      = 1'b1;
                                top_next   = stk_rd_reg;
                                level_next = level_reg - 1'b1;
                                pc_next    = step5;
                            end
                        end
                        OP_LOAD: begin
                            if (stack_full) begin
                                stopped_next = 1'b1;
                                fault_next   = FLT_OVERFLOW;
                            end else if (!in_range) begin
                                stopped_next = 1'b1;
                                fault_next   = FLT_BAD_INDEX;
                            end else begin
                                stk_we     = !stack_empty;
                                top_next   = wm_rd_reg;
                                level_next = level_reg + 1'b1;
                                pc_next    = step5;
                            end
                        end
                        OP_JMP: begin
                            pc_next = target;
                        end
                        OP_JZ, OP_JNZ: begin
                            if (stack_empty) begin
                                stopped_next = 1'b1;
                                fault_next   = FLT_UNDERFLOW;
                            end else begin
                                top_next   = stk_rd_reg;
                                level_next = level_reg - 1'b1;
                                if ((op_reg == OP_JZ) == (top_reg == '0)) begin
                                    pc_next = target;
                                end else begin
                                    pc_next = step5;
                                end
                            end
                        end
                        OP_DUP: begin
                            if (stack_empty) begin
                                stopped_next = 1'b1;
                                fault_next   = FLT_UNDERFLOW;
                            end else if (stack_full) begin
                                stopped_next = 1'b1;
                                fault_next   = FLT_OVERFLOW;
                            end else begin
                                stk_we     = 1'b1;
                                level_next = level_reg + 1'b1;
                                pc_next    = step1;
                            end
                        end
                        OP_CALL: begin
                            if (rlevel_reg == RLW'(RETURN_DEPTH)) begin
                                stopped_next = 1'b1;
                                fault_next   = FLT_RET_OVER;
                            end else begin
                                ret_we      = 1'b1;
                                rlevel_next = rlevel_reg + 1'b1;
                                pc_next     = target;
                            end
                        end
                        OP_RET: begin
                            if (rlevel_reg == '0) begin
                                stopped_next = 1'b1;
                                fault_next   = FLT_RET_UNDER;
                            end else begin
                                rlevel_next = rlevel_reg - 1'b1;
                                pc_next     = ret_rd_reg;
                            end
                        end
                        default: begin
                            stopped_next = 1'b1;
                            fault_next   = FLT_BAD_OP;
                        end
                    endcase
                end
            end
            ST_ALU: begin
                // two operands collapse into the result
                if (alu_done) begin
                    top_next   = alu_result;
                    level_next = level_reg - 1'b1;
                    pc_next    = step1;
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = accept ? ST_EXEC : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            level_reg   <= '0;
            rlevel_reg  <= '0;
            pc_reg      <= '0;
            stopped_reg <= 1'b0;
            fault_reg   <= FLT_NONE;
            tally_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            level_reg   <= level_next;
            rlevel_reg  <= rlevel_next;
            pc_reg      <= pc_next;
            stopped_reg <= stopped_next;
            fault_reg   <= fault_next;
            tally_reg   <= tally_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            // a new status replaces the one taken in the same cycle
            if (state_reg == ST_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        if (accept) begin
            op_reg  <= s_action;
            imm_reg <= s_immediate;
        end
        if (state_reg == ST_RESP && out_free) begin
            o_pc_reg     <= 16'(pc_reg);
            o_top_reg    <= stack_empty ? '0 : top_reg;
            o_depth_reg  <= 9'(level_reg);
            o_halted_reg <= stopped_reg;
            o_fault_reg  <= fault_reg;
            o_count_reg  <= tally_reg;
        end
    end

    // data stack: entries below the top register
    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stack_mem[SAW'(level_reg - 1'b1)] <= top_reg;
        end
        stk_rd_reg <= stack_mem[SAW'(level_reg - LW'(2))];
    end

    // return address stack
    always_ff @(posedge aclk) begin
        if (ret_we) begin
            ret_mem[RAW'(rlevel_reg)] <= step5;
        end
        ret_rd_reg <= ret_mem[RAW'(rlevel_reg - 1'b1)];
    end

    // word memory, read address taken straight from the input transaction
    always_ff @(posedge aclk) begin
        if (wm_we) begin
            word_mem[wm_wa] <= wm_wd;
        end
        wm_rd_reg <= word_mem[s_immediate[MAW-1:0]];
    end

    assign m_valid          = m_valid_reg;
    assign m_next_pc        = o_pc_reg;
    assign m_top_value      = o_top_reg;
    assign m_depth          = o_depth_reg;
    assign m_halted         = o_halted_reg;
    assign m_fault          = o_fault_reg;
    assign m_executed_count = o_count_reg;

    // a fault always comes with a stop
    a_fault_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (fault_reg != FLT_NONE) |-> stopped_reg)
        else $error("fault latched without stop");

    // a stopped machine stays stopped until reset
    a_stop_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> stopped_reg)
        else $error("stop released without reset");

    // stack levels stay within capacity
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (level_reg <= LW'(STACK_DEPTH)) && (rlevel_reg <= RLW'(RETURN_DEPTH)))
        else $error("stack level out of range");

endmodule

`default_nettype wire

[hw/rtl/sme_alu.sv]
// shared arithmetic unit: add, sub, mul, compare with a registered result, bit-serial signed divide
// depends on sme_pkg
`default_nettype none

module sme_alu import sme_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire alu_req_t          req,
    input  wire logic [DATA_W-1:0] opa,
    input  wire logic [DATA_W-1:0] opb,
    output logic                   done,
    output logic [DATA_W-1:0]      result
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dvs_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] result_reg;

    logic [DATA_W-1:0] a_mag;
    logic [DATA_W-1:0] b_mag;
    logic [DATA_W-1:0] quick;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;
    logic [DATA_W-1:0] rem_step;
    logic [DATA_W-1:0] quo_step;

    assign a_mag = opa[DATA_W-1] ? (~opa + 1'b1) : opa;
    assign b_mag = opb[DATA_W-1] ? (~opb + 1'b1) : opb;

    always_comb begin
        case (req.op)
            ALU_ADD: quick = opa + opb;
            ALU_SUB: quick = opa - opb;
            ALU_MUL: quick = opa * opb;
            ALU_CMP: quick = DATA_W'($signed(opa) < $signed(opb));
            default: quick = '0;
        endcase
    end

    // one quotient bit per cycle, restoring
    always_comb begin
        shifted = {rem_reg, quo_reg[DATA_W-1]};
        trial   = shifted - {1'b0, dvs_reg};
        if (!trial[DATA_W]) begin
            rem_step = trial[DATA_W-1:0];
            quo_step = {quo_reg[DATA_W-2:0], 1'b1};
        end else begin
            rem_step = shifted[DATA_W-1:0];
            quo_step = {quo_reg[DATA_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (busy_reg) begin
                rem_reg <= rem_step;
                quo_reg <= quo_step;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg   <= 1'b0;
                    done_reg   <= 1'b1;
                    result_reg <= neg_reg ? (~quo_step + 1'b1) : quo_step;
                end
            end else if (req.start) begin
                if (req.op == ALU_DIV) begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                    rem_reg  <= '0;
                    quo_reg  <= a_mag;
                    dvs_reg  <= b_mag;
                    neg_reg  <= opa[DATA_W-1] ^ opb[DATA_W-1];
                end else begin
                    done_reg   <= 1'b1;
                    result_reg <= quick;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[bench/sme_checker.sv]
// checker for the stack machine executor: watches both channels, predicts every status
// transaction from its own copy of the machine state and compares the whole status at once
// depends on sme_pkg
`default_nettype none

module sme_checker import sme_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic [7:0]         s_action,
    input  wire logic signed [31:0] s_immediate,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic [15:0]        m_next_pc,
    input  wire logic signed [31:0] m_top_value,
    input  wire logic [8:0]         m_depth,
    input  wire logic               m_halted,
    input  wire logic [2:0]         m_fault,
    input  wire logic [31:0]        m_executed_count,
    output int                      mismatches,
    output int                      outstanding,
    output int                      statuses_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_N = DEF_STACK_DEPTH;
    localparam int MEM_N   = DEF_MEM_WORDS;
    localparam int RET_N   = DEF_RETURN_DEPTH;

    typedef struct packed {
        logic [15:0] pc;
        logic [31:0] top;
        logic [8:0]  depth;
        logic        halted;
        logic [2:0]  fault;
        logic [31:0] count;
    } status_t;

    logic [31:0] vm_stack [STACK_N];
    logic [15:0] vm_returns [RET_N];
    logic [31:0] vm_mem [MEM_N];
    int          vm_level;
    int          vm_ret_level;
    logic [15:0] vm_pc;
    logic        vm_stopped;
    logic [2:0]  vm_fault;
    logic [31:0] vm_count;

    status_t status_q[$];

    task automatic halt_with(input logic [2:0] code);
        vm_stopped = 1'b1;
        vm_fault   = code;
    endtask

    // one instruction against the shadow machine, returns the status it reports
    task automatic run_instruction(input logic [7:0] op, input logic [31:0] imm,
                                   output status_t st);
        logic [15:0] pc;
        logic [15:0] next5;
        logic [15:0] next1;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        longint      q;
        longint      simm;
        logic        take;
        pc    = vm_pc;
        next5 = vm_pc + 16'd5;
        next1 = vm_pc + 16'd1;
        simm  = longint'($signed(imm));
        if (!vm_stopped) begin
            if (vm_count != 32'hFFFF_FFFF) vm_count++;
            case (op)
                OP_HALT: vm_stopped = 1'b1;
                OP_PUSH: begin
                    if (vm_level >= STACK_N) halt_with(FLT_OVERFLOW);
                    else begin
                        vm_stack[vm_level] = imm;
                        vm_level++;
                        pc = next5;
                    end
                end
                OP_POP: begin
                    if (vm_level < 1) halt_with(FLT_UNDERFLOW);
                    else begin
                        vm_level--;
                        pc = next1;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP: begin
                    if (vm_level < 2) halt_with(FLT_UNDERFLOW);
                    else begin
                        vm_level--;
                        b = vm_stack[vm_level];
                        if (op == OP_DIV && b == 32'd0) halt_with(FLT_DIV_ZERO);
                        else begin
                            vm_level--;
                            a = vm_stack[vm_level];
                            case (op)
                                OP_ADD: r = a + b;
                                OP_SUB: r = a - b;
                                OP_MUL: r = a * b;
                                OP_DIV: begin
                                    // 64-bit quotient so most-negative / -1 wraps
                                    q = longint'($signed(a)) / longint'($signed(b));
                                    r = q[31:0];
                                end
                                default: r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                            endcase
                            vm_stack[vm_level] = r;
                            vm_level++;
                            pc = next1;
                        end
                    end
                end
                OP_STORE: begin
                    if (vm_level < 1) halt_with(FLT_UNDERFLOW);
                    else if (simm < 0 || simm >= MEM_N) halt_with(FLT_BAD_INDEX);
                    else begin
                        vm_level--;
                        vm_mem[simm] = vm_stack[vm_level];
                        pc = next5;
                    end
                end
                OP_LOAD: begin
                    if (vm_level >= STACK_N) halt_with(FLT_OVERFLOW);
                    else if (simm < 0 || simm >= MEM_N) halt_with(FLT_BAD_INDEX);
                    else begin
                        vm_stack[vm_level] = vm_mem[simm];
                        vm_level++;
                        pc = next5;
                    end
                end
                OP_JMP: pc = imm[15:0];
                OP_JZ, OP_JNZ: begin
                    if (vm_level < 1) halt_with(FLT_UNDERFLOW);
                    else begin
                        vm_level--;
                        take = (op == OP_JZ) ? (vm_stack[vm_level] == 32'd0)
                                             : (vm_stack[vm_level] != 32'd0);
                        pc = take ? imm[15:0] : next5;
                    end
                end
                OP_DUP: begin
                    if (vm_level < 1) halt_with(FLT_UNDERFLOW);
                    else if (vm_level >= STACK_N) halt_with(FLT_OVERFLOW);
                    else begin
                        vm_stack[vm_level] = vm_stack[vm_level - 1];
                        vm_level++;
                        pc = next1;
                    end
                end
                OP_CALL: begin
                    if (vm_ret_level >= RET_N) halt_with(FLT_RET_OVER);
                    else begin
                        vm_returns[vm_ret_level] = next5;
                        vm_ret_level++;
                        pc = imm[15:0];
                    end
                end
                OP_RET: begin
                    if (vm_ret_level == 0) halt_with(FLT_RET_UNDER);
                    else begin
                        vm_ret_level--;
                        pc = vm_returns[vm_ret_level];
                    end
                end
                default: halt_with(FLT_BAD_OP);
            endcase
            vm_pc = pc;
        end
        st.pc     = vm_pc;
        st.top    = (vm_level > 0) ? vm_stack[vm_level - 1] : 32'd0;
        st.depth  = 9'(vm_level);
        st.halted = vm_stopped;
        st.fault  = vm_fault;
        st.count  = vm_count;
    endtask

    always @(posedge aclk) begin
        status_t want;
        status_t got;
        if (!aresetn) begin
            for (int i = 0; i < MEM_N; i++) vm_mem[i] = '0;
            vm_level     = 0;
            vm_ret_level = 0;
            vm_pc        = '0;
            vm_stopped   = 1'b0;
            vm_fault     = FLT_NONE;
            vm_count     = '0;
            status_q.delete();
            mismatches    = 0;
            statuses_seen = 0;
        end else begin
            if (s_valid && s_ready) begin
                run_instruction(s_action, s_immediate, want);
                status_q.push_back(want);
            end
            if (m_valid && m_ready) begin
                statuses_seen++;
                got = {m_next_pc, m_top_value, m_depth, m_halted, m_fault, m_executed_count};
                if (status_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: status with nothing outstanding: %p", $realtime, got);
                end else begin
                    want = status_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: status mismatch\n  expected %p\n  actual   %p",
                                     $realtime, want, got);
                    end
                end
            end
        end
        outstanding = status_q.size();
    end

endmodule

`default_nettype wire

[bench/tb_top.sv]
// top of the stack machine executor bench: clock, reset, instruction stimulus, ready
// throttling and the verdict; depends on sme_pkg, stack_machine_executor and sme_checker
`default_nettype none

module tb_top;
    import sme_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_action;
    logic signed [31:0] s_immediate;
    logic               m_valid;
    logic               m_ready;
    logic [15:0]        m_next_pc;
    logic signed [31:0] m_top_value;
    logic [8:0]         m_depth;
    logic               m_halted;
    logic [2:0]         m_fault;
    logic [31:0]        m_executed_count;

    int mismatches;
    int outstanding;
    int statuses_seen;

    // idle mode: 0 none, 1 sender gaps, 2 receiver stalls, 3 both
    int idle_mode;
    // bumping this asks the ready process for one long hold-off
    int hold_request;

    // stimulus-side bookkeeping so the random program stays legal
    int stack_fill;
    int call_fill;
    int sent;

    localparam int STACK_N = DEF_STACK_DEPTH;
    localparam int MEM_N   = DEF_MEM_WORDS;
    localparam int RET_N   = DEF_RETURN_DEPTH;

    stack_machine_executor u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_immediate      (s_immediate),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_next_pc        (m_next_pc),
        .m_top_value      (m_top_value),
        .m_depth          (m_depth),
        .m_halted         (m_halted),
        .m_fault          (m_fault),
        .m_executed_count (m_executed_count)
    );

    sme_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_immediate      (s_immediate),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_next_pc        (m_next_pc),
        .m_top_value      (m_top_value),
        .m_depth          (m_depth),
        .m_halted         (m_halted),
        .m_fault          (m_fault),
        .m_executed_count (m_executed_count),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .statuses_seen    (statuses_seen)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side ready: random stalls per mode, plus a long hold-off on request
    always @(negedge aclk) begin
        int seen_request;
        int hold_left;
        if (hold_request != seen_request) begin
            seen_request = hold_request;
            hold_left    = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (idle_mode == 2) begin
            m_ready <= ($urandom_range(99) >= 77);
        end else if (idle_mode == 3) begin
            m_ready <= ($urandom_range(99) >= 32);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // safety net against a hung handshake
    initial begin
        #20ms;
        $display("stack_machine_executor regression: fail");
        $finish;
    end

    // one instruction transaction; entered and left at a falling edge
    task automatic send(input logic [7:0] op, input logic [31:0] imm);
        int idle_pct;
        idle_pct = (idle_mode == 1) ? 77 : ((idle_mode == 3) ? 32 : 0);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_valid     <= 1'b1;
        s_action    <= op;
        s_immediate <= imm;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        sent++;
    endtask

    // send and keep the legality bookkeeping in step
    task automatic issue(input logic [7:0] op, input logic [31:0] imm);
        send(op, imm);
        case (op) inside
            OP_PUSH, OP_LOAD, OP_DUP:                stack_fill++;
            OP_POP, OP_STORE, OP_JZ, OP_JNZ:         stack_fill--;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP:  stack_fill--;
            OP_CALL:                                 call_fill++;
            OP_RET:                                  call_fill--;
            default: ;
        endcase
    endtask

    // random 32-bit value with extra weight on the edges
    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'($urandom_range(15));
            default: return $urandom();
        endcase
    endfunction

    // one legal random instruction (a divide brings its own nonzero divisor)
    task automatic random_instruction();
        logic [31:0] v;
        bit          done;
        done = 0;
        while (!done) begin
            case ($urandom_range(14)) inside
                0, 1: if (stack_fill < STACK_N) begin
                    issue(OP_PUSH, pick_value()); done = 1;
                end
                2: if (stack_fill >= 1) begin issue(OP_POP, $urandom()); done = 1; end
                3: if (stack_fill >= 2) begin
                    issue(OP_ADD + 8'($urandom_range(1)), $urandom()); done = 1;
                end
                4: if (stack_fill >= 2) begin
                    issue($urandom_range(1) ? OP_MUL : OP_CMP, $urandom()); done = 1;
                end
                5: if (stack_fill >= 1 && stack_fill < STACK_N) begin
                    do v = pick_value(); while (v == 32'd0);
                    issue(OP_PUSH, v);
                    issue(OP_DIV, $urandom());
                    done = 1;
                end
                6: if (stack_fill >= 1) begin
                    issue(OP_STORE, $urandom_range(MEM_N - 1)); done = 1;
                end
                7: if (stack_fill < STACK_N) begin
                    issue(OP_LOAD, $urandom_range(MEM_N - 1)); done = 1;
                end
                8: begin issue(OP_JMP, $urandom()); done = 1; end
                9, 10: if (stack_fill >= 1) begin
                    issue($urandom_range(1) ? OP_JZ : OP_JNZ, $urandom()); done = 1;
                end
                11: if (stack_fill >= 1 && stack_fill < STACK_N) begin
                    issue(OP_DUP, $urandom()); done = 1;
                end
                12: if (call_fill < RET_N) begin issue(OP_CALL, $urandom()); done = 1; end
                default: if (call_fill > 0) begin issue(OP_RET, $urandom()); done = 1; end
            endcase
        end
    endtask

    // fill both stacks to the brim, then run on from there
    task automatic fill_burst();
        while (stack_fill < STACK_N) issue(OP_PUSH, $urandom());
        while (call_fill < RET_N) issue(OP_CALL, $urandom());
    endtask

    initial begin
        int fault_pick;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_action    = '0;
        s_immediate = '0;
        m_ready     = 1'b0;
        idle_mode   = 0;
        hold_request = 0;
        stack_fill  = 0;
        call_fill   = 0;
        sent        = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: edge values, every opcode but halt and pop, wrap and truncation cases
        issue(OP_PUSH, 32'h7FFF_FFFF);
        issue(OP_PUSH, 32'h0000_0001);
        issue(OP_ADD, 32'd0);                 // wraps to most negative
        issue(OP_PUSH, 32'hFFFF_FFFF);
        issue(OP_DIV, 32'd0);                 // most negative / -1 wraps
        issue(OP_PUSH, -32'sd7);
        issue(OP_PUSH, 32'd2);
        issue(OP_DIV, 32'd0);                 // truncates toward zero: -3
        issue(OP_PUSH, 32'h0001_0001);
        issue(OP_MUL, 32'd0);
        issue(OP_PUSH, 32'd5);
        issue(OP_SUB, 32'd0);
        issue(OP_PUSH, 32'd1);
        issue(OP_CMP, 32'd0);                 // signed: negative < 1
        issue(OP_STORE, MEM_N - 1);
        issue(OP_LOAD, MEM_N - 1);
        issue(OP_LOAD, 32'd0);                // untouched word reads zero
        issue(OP_STORE, 32'd0);
        issue(OP_DUP, 32'd0);
        issue(OP_JZ, 32'h8000_1234);          // not taken
        issue(OP_JNZ, -32'sd1);               // taken, negative target
        issue(OP_PUSH, 32'd0);                // pc wraps past the top
        issue(OP_JZ, 32'h0000_0040);          // taken
        issue(OP_CALL, 32'hFFFF_FFFB);        // target near the top of the pc range
        issue(OP_RET, 32'd0);
        issue(OP_JMP, 32'h1234_5678);

        // random phases with different idling, long receiver hold-off in the first
        for (int phase = 0; phase < 4; phase++) begin
            idle_mode = phase;
            if (phase == 0) hold_request++;
            if (phase == 2) fill_burst();
            for (int n = 0; n < 400; n++) random_instruction();
        end

        // exactly one stopping case per run, picked at random
        idle_mode  = $urandom_range(3);
        fault_pick = $urandom_range(7);
        case (fault_pick)
            0: issue(OP_HALT, $urandom());
            1: begin
                while (stack_fill > 0) issue(OP_POP, 32'd0);
                issue($urandom_range(1) ? OP_STORE : OP_ADD + 8'($urandom_range(4)), 32'd0);
            end
            2: begin
                while (stack_fill < STACK_N) issue(OP_PUSH, $urandom());
                issue($urandom_range(1) ? OP_LOAD : OP_PUSH, 32'd3);
            end
            3: begin
                if (stack_fill == 0) issue(OP_PUSH, $urandom());
                if (stack_fill == STACK_N) issue(OP_POP, 32'd0);
                issue(OP_PUSH, 32'd0);
                issue(OP_DIV, 32'd0);
            end
            4: begin
                while (call_fill > 0) issue(OP_RET, 32'd0);
                issue(OP_RET, 32'd0);
            end
            5: issue(8'($urandom_range(255, 16)), $urandom());
            6: begin
                if (stack_fill == 0) issue(OP_PUSH, $urandom());
                if (stack_fill == STACK_N) issue(OP_POP, 32'd0);
                issue($urandom_range(1) ? OP_STORE : OP_LOAD,
                      $urandom_range(1) ? 32'(MEM_N) : 32'h8000_0000 | $urandom());
            end
            default: begin
                while (call_fill < RET_N) issue(OP_CALL, $urandom());
                issue(OP_CALL, 32'd0);
            end
        endcase

        // stopped machine: anything goes, status must stay frozen
        for (int n = 0; n < 24; n++) send(8'($urandom_range(255)), $urandom());
        s_valid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("ran %0d instructions over four idling phases, %0d status transactions checked",
                 sent, statuses_seen);
        $display("closing stop case %0d, %0d mismatches", fault_pick, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("stack_machine_executor regression: pass");
        else
            $display("stack_machine_executor regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

[stack_machine_executor.f]
hw/rtl/sme_pkg.sv
hw/rtl/sme_alu.sv
hw/rtl/stack_machine_executor.sv
bench/sme_checker.sv
bench/tb_top.sv
